// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define WSTA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define WSTA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/wsta_pkg.sv -----
package wsta_pkg;

   // Default number of servers held in storage.
   localparam int MAX_SERVERS_DEF = 16;

   // Fixed field widths of the request, response and register.
   localparam int FUNC_W   = 2;
   localparam int SIDX_W   = 4;
   localparam int WEIGHT_W = 16;
   localparam int DUR_W    = 16;
   localparam int TIME_W   = 48;
   localparam int CLOCK_W  = 32;
   localparam int CSR_W    = 5;

   localparam logic [CSR_W-1:0] SERVERS_IN_USE_RST = CSR_W'(16);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ARRIVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

endpackage

// ----- src/weighted_server_task_assigner.sv -----
// A task arrival's response follows a scan of the n active servers, a drain and an update,
// n being the active server count (servers in use, at least one, at most MAX_SERVERS).
// Requests stall until the arrival commits, which waits while a response is stalled.
// Weight loads and restarts complete at once and give no response.
// Synchronous active-high reset clears control state, free times, the arrival clock,
// and sets servers_in_use to 16; server weights stay undefined until loaded.
module weighted_server_task_assigner #(
   parameter int MAX_SERVERS = wsta_pkg::MAX_SERVERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wsta_pkg::FUNC_W-1:0]     req_func,
   input  logic [wsta_pkg::SIDX_W-1:0]     req_server_index,
   input  logic [wsta_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic [wsta_pkg::DUR_W-1:0]      req_duration,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wsta_pkg::SIDX_W-1:0]     rsp_assigned_server,
   output logic [wsta_pkg::TIME_W-1:0]     rsp_finish_time,
   // Configuration write channel for servers_in_use.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wsta_pkg::CSR_W-1:0]      csr_data
);

   // Width of a server address, and of a count that can hold MAX_SERVERS itself.
   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   // Common width for comparing the register against the server limit.
   localparam int CMP_W = (CNT_W > wsta_pkg::CSR_W) ? CNT_W : wsta_pkg::CSR_W;
   localparam int TW    = wsta_pkg::TIME_W;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   wsta_pkg::state_type state_ff, state_in;

   logic [wsta_pkg::CSR_W-1:0]    servers_in_use_ff, servers_in_use_in;
   logic [wsta_pkg::CLOCK_W-1:0]  clock_ff, clock_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]              last_ff, last_in;
   logic [wsta_pkg::DUR_W-1:0]    dur_ff, dur_in;

   // Candidate pipeline stage: the registered memory read for one server.
   logic                          cand_vld_ff, cand_vld_in;
   logic [IDX_W-1:0]              cand_idx_ff;
   logic                          cand_ok_ff;
   logic [wsta_pkg::WEIGHT_W-1:0] wt_rd_ff;
   logic [TW-1:0]                 ft_rd_ff;

   // Best idle server found so far.
   logic                          idle_found_ff, idle_found_in;
   logic [IDX_W-1:0]              idle_idx_ff, idle_idx_in;
   logic [wsta_pkg::WEIGHT_W-1:0] idle_wt_ff, idle_wt_in;

   // Best server by earliest free time, then weight, then index.
   logic [IDX_W-1:0]              bus_idx_ff, bus_idx_in;
   logic [wsta_pkg::WEIGHT_W-1:0] bus_wt_ff, bus_wt_in;
   logic [TW-1:0]                 bus_ft_ff, bus_ft_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wsta_pkg::SIDX_W-1:0]   rsp_server_ff, rsp_server_in;
   logic [TW-1:0]                 rsp_time_ff, rsp_time_in;

   // Weight and free-time memories. Free times carry one valid bit per entry
   // so that reset and restart clear them at once; an invalid entry reads zero.
   logic [wsta_pkg::WEIGHT_W-1:0] wt_mem [MAX_SERVERS];
   logic [TW-1:0]                 ft_mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0]        ft_vld_ff, ft_vld_in;

   // ---------------------------------------------------------------------
   // Request decode.
   // ---------------------------------------------------------------------
   logic                    req_accept;
   logic                    is_load, is_arrive, is_restart;
   logic [IDX_W+wsta_pkg::SIDX_W-1:0] load_idx_wide;
   logic [IDX_W-1:0]        load_addr;
   logic                    load_in_range;

   assign req_accept    = req_valid && !req_stall;
   assign is_load       = req_accept && (req_func == wsta_pkg::FUNC_LOAD);
   assign is_arrive     = req_accept && (req_func == wsta_pkg::FUNC_ARRIVE);
   assign is_restart    = req_accept && (req_func == wsta_pkg::FUNC_RESTART);
   assign load_idx_wide = {{IDX_W{1'b0}}, req_server_index};
   assign load_addr     = load_idx_wide[IDX_W-1:0];
   assign load_in_range = (int'(req_server_index) < MAX_SERVERS);

   // Active server count: zero counts as one, and it never exceeds storage.
   logic [CMP_W-1:0] use_w, max_w, cnt_w, last_w;

   always_comb begin
      use_w = CMP_W'(servers_in_use_ff);
      max_w = CMP_W'(MAX_SERVERS);
      if (use_w == '0) begin
         cnt_w = CMP_W'(1);
      end else if (use_w > max_w) begin
         cnt_w = max_w;
      end else begin
         cnt_w = use_w;
      end
      last_w = cnt_w - CMP_W'(1);
   end

   // ---------------------------------------------------------------------
   // Shared compare unit: looks at one candidate server per cycle.
   // ---------------------------------------------------------------------
   logic [TW-1:0] cand_ft;
   logic [TW-1:0] now_w;
   logic          cand_idle;
   logic          take_idle;
   logic          take_bus;

   always_comb begin
      now_w     = TW'(clock_ff);
      cand_ft   = cand_ok_ff ? ft_rd_ff : '0;
      cand_idle = (cand_ft <= now_w);
      take_idle = cand_vld_ff && cand_idle && (!idle_found_ff || (wt_rd_ff < idle_wt_ff));
      // Server zero is always the first candidate and seeds the busy tracker.
      take_bus  = cand_vld_ff && ((cand_idx_ff == '0) || (cand_ft < bus_ft_ff) ||
                  ((cand_ft == bus_ft_ff) && (wt_rd_ff < bus_wt_ff)));
   end

   // ---------------------------------------------------------------------
   // Finish time: one saturating 48-bit add on the winner's base time.
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]              win_idx;
   logic [TW-1:0]                 base_time;
   logic [TW:0]                   sum_time;
   logic [TW-1:0]                 finish_time;
   logic [IDX_W+wsta_pkg::SIDX_W-1:0] win_idx_wide;

   always_comb begin
      win_idx      = idle_found_ff ? idle_idx_ff : bus_idx_ff;
      base_time    = idle_found_ff ? now_w : bus_ft_ff;
      sum_time     = {1'b0, base_time} + (TW + 1)'(dur_ff);
      finish_time  = sum_time[TW] ? {TW{1'b1}} : sum_time[TW-1:0];
      win_idx_wide = {{wsta_pkg::SIDX_W{1'b0}}, win_idx};
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state and datapath controls.
   // ---------------------------------------------------------------------
   logic commit;

   always_comb begin
      state_in          = state_ff;
      req_stall         = 1'b1;
      commit            = 1'b0;
      rd_idx_in         = rd_idx_ff;
      last_in           = last_ff;
      dur_in            = dur_ff;
      cand_vld_in       = 1'b0;
      idle_found_in     = idle_found_ff;
      idle_idx_in       = idle_idx_ff;
      idle_wt_in        = idle_wt_ff;
      bus_idx_in        = bus_idx_ff;
      bus_wt_in         = bus_wt_ff;
      bus_ft_in         = bus_ft_ff;

      case (state_ff)
         wsta_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (is_arrive) begin
               // Latch the task and the scan range, and clear the idle tracker.
               rd_idx_in     = '0;
               last_in       = last_w[IDX_W-1:0];
               dur_in        = req_duration;
               idle_found_in = 1'b0;
               state_in      = wsta_pkg::ST_SCAN;
            end
         end
         wsta_pkg::ST_SCAN: begin
            // The read of server rd_idx_ff is issued this cycle.
            cand_vld_in = 1'b1;
            if (rd_idx_ff == last_ff) begin
               state_in = wsta_pkg::ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         wsta_pkg::ST_DRAIN: begin
            // The last candidate is compared in this cycle.
            state_in = wsta_pkg::ST_UPDATE;
         end
         wsta_pkg::ST_UPDATE: begin
            // Commit once the response register is free or being drained.
            if (!rsp_valid_ff || !rsp_stall) begin
               commit   = 1'b1;
               state_in = wsta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsta_pkg::ST_IDLE;
         end
      endcase

      if (take_idle) begin
         idle_found_in = 1'b1;
         idle_idx_in   = cand_idx_ff;
         idle_wt_in    = wt_rd_ff;
      end
      if (take_bus) begin
         bus_idx_in = cand_idx_ff;
         bus_wt_in  = wt_rd_ff;
         bus_ft_in  = cand_ft;
      end
   end

   // Configuration, arrival clock, free-time valid bits and response register.
   always_comb begin
      servers_in_use_in = servers_in_use_ff;
      if (csr_valid && csr_ready) begin
         servers_in_use_in = csr_data;
      end

      clock_in  = clock_ff;
      ft_vld_in = ft_vld_ff;
      if (is_restart) begin
         clock_in  = '0;
         ft_vld_in = '0;
      end else if (commit) begin
         ft_vld_in[win_idx] = 1'b1;
         if (clock_ff != {wsta_pkg::CLOCK_W{1'b1}}) begin
            clock_in = clock_ff + wsta_pkg::CLOCK_W'(1);
         end
      end

      rsp_server_in = rsp_server_ff;
      rsp_time_in   = rsp_time_ff;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_server_in = win_idx_wide[wsta_pkg::SIDX_W-1:0];
         rsp_time_in   = finish_time;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end else begin
         rsp_valid_in  = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Clocked logic.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= wsta_pkg::ST_IDLE;
         servers_in_use_ff <= wsta_pkg::SERVERS_IN_USE_RST;
         clock_ff          <= '0;
         ft_vld_ff         <= '0;
         cand_vld_ff       <= 1'b0;
         idle_found_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         servers_in_use_ff <= servers_in_use_in;
         clock_ff          <= clock_in;
         ft_vld_ff         <= ft_vld_in;
         cand_vld_ff       <= cand_vld_in;
         idle_found_ff     <= idle_found_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      last_ff       <= last_in;
      dur_ff        <= dur_in;
      idle_idx_ff   <= idle_idx_in;
      idle_wt_ff    <= idle_wt_in;
      bus_idx_ff    <= bus_idx_in;
      bus_wt_ff     <= bus_wt_in;
      bus_ft_ff     <= bus_ft_in;
      rsp_server_ff <= rsp_server_in;
      rsp_time_ff   <= rsp_time_in;
   end

   // Memory ports: one registered read at the scan address, one write each.
   always_ff @(posedge clock) begin
      cand_idx_ff <= rd_idx_ff;
      cand_ok_ff  <= ft_vld_ff[rd_idx_ff];
      wt_rd_ff    <= wt_mem[rd_idx_ff];
      ft_rd_ff    <= ft_mem[rd_idx_ff];
      if (is_load && load_in_range) begin
         wt_mem[load_addr] <= req_weight;
      end
      if (commit) begin
         ft_mem[win_idx] <= finish_time;
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_assigned_server = rsp_server_ff;
   assign rsp_finish_time     = rsp_time_ff;

endmodule

// ----- src/wsta_checker.sv -----
`include "assert_macros.svh"

module wsta_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [wsta_pkg::FUNC_W-1:0]   req_func,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [wsta_pkg::SIDX_W-1:0]   rsp_assigned_server,
   input logic [wsta_pkg::TIME_W-1:0]   rsp_finish_time
);

   logic req_accept;
   logic arrive_accept;
   logic other_accept;
   logic rsp_held;
   logic [wsta_pkg::SIDX_W+wsta_pkg::TIME_W-1:0] rsp_payload;

   assign req_accept    = req_valid && !req_stall;
   assign arrive_accept = req_accept && (req_func == wsta_pkg::FUNC_ARRIVE);
   assign other_accept  = req_accept && (req_func != wsta_pkg::FUNC_ARRIVE);
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_payload   = {rsp_assigned_server, rsp_finish_time};

   // A stalled response stays valid.
   `WSTA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid)

   // A stalled response keeps its payload.
   `WSTA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_payload))

   // An accepted arrival starts a scan, so the request side stalls next cycle.
   `WSTA_ASSERT_NEXT(a_arrive_busy, clock, reset, arrive_accept, req_stall)

   // Loads, restarts and unused codes finish at once and leave the block ready.
   `WSTA_ASSERT_NEXT(a_other_ready, clock, reset, other_accept, !req_stall)

endmodule

bind weighted_server_task_assigner wsta_checker u_wsta_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_func            (req_func),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_assigned_server (rsp_assigned_server),
   .rsp_finish_time     (rsp_finish_time)
);
